// ===== src/pedq_pkg.sv =====
// ============================================================================
// pedq_pkg: shared types and constants of the priority event queue dispatcher
// Item formats, result codes, configuration indexes and the control and
// status bundles between controller and datapath.
// ============================================================================
package pedq_pkg;

    localparam int NUM_QUEUES      = 13;
    localparam int QUEUE_DEPTH     = 16;
    localparam int LOWEST_PRIORITY = 20;

    localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ID_W        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int QLEN_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int EVENT_W     = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int LEN_FIELD_W = 5;
    localparam int QLEN_RESET  = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGISTERED_MASK = 2'd1;

    localparam logic OP_POST    = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    localparam logic [1:0] KIND_POST     = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_IDLE     = 2'd2;

    localparam logic [1:0] ST_ACCEPTED     = 2'd0;
    localparam logic [1:0] ST_FULL         = 2'd1;
    localparam logic [1:0] ST_UNREGISTERED = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [7:0]  priority_level;
        logic [31:0] event_signal;
        logic [31:0] event_parameter;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  post_status;
        logic [5:0]  served_priority;
        logic [31:0] out_signal;
        logic [31:0] out_parameter;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic post_do;
        logic load_idle;
        logic scan_do;
        logic load_disp;
    } cmd_t;

    typedef struct packed {
        logic any_pending;
        logic todo_empty;
        logic out_free;
    } stat_t;

endpackage

// ===== src/pedq_ram.sv =====
// ============================================================================
// pedq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module pedq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 208
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pedq_ctrl.sv =====
// ============================================================================
// pedq_ctrl: sequencing of posts and service passes
// Accepts one item at a time and steps the datapath through a post or a
// service pass, each dispatched event being a memory read and then a result load.
// ============================================================================
module pedq_ctrl
    import pedq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  logic  op,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_POST    = 3'd1;
    localparam logic [2:0] S_IDLERES = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_DOUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.latch = 1'b1;
                    if (op == OP_POST)
                    begin
                        state_next = S_POST;
                    end
                    else if (stat.any_pending)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLERES;
                    end
                end
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.post_do = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLERES:
            begin
                if (stat.out_free)
                begin
                    cmd.load_idle = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_do = 1'b1;
                state_next  = S_DOUT;
            end
            S_DOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_disp = 1'b1;
                    state_next    = stat.todo_empty ? S_IDLE : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.post_do || cmd.load_idle || cmd.load_disp) |-> stat.out_free)
        else $error("result loaded while output register busy");

    a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_do |-> !stat.todo_empty)
        else $error("scan issued with no queue left to serve");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch, cmd.post_do, cmd.load_idle, cmd.scan_do, cmd.load_disp}))
        else $error("more than one datapath command at once");

endmodule

// ===== src/pedq_dp.sv =====
// ============================================================================
// pedq_dp: queue state, event store and result register
// Holds ring indexes and full flags per queue, the configuration registers,
// the event memory and the outgoing result.
// ============================================================================
module pedq_dp
    import pedq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  in_item_t               item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output out_item_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    in_item_t                 item_reg;
    logic [NUM_QUEUES-1:0]    todo_reg;
    logic [NUM_QUEUES-1:0]    todo_next;
    logic [ID_W-1:0]          disp_id_reg;
    logic [QLEN_W-1:0]        qlen_reg;
    logic [QLEN_W-1:0]        qlen_next;
    logic [NUM_QUEUES-1:0]    mask_reg;
    logic [NUM_QUEUES-1:0]    mask_next;
    logic [IDX_W-1:0]         rd_reg [NUM_QUEUES];
    logic [IDX_W-1:0]         rd_next [NUM_QUEUES];
    logic [IDX_W-1:0]         wr_reg [NUM_QUEUES];
    logic [IDX_W-1:0]         wr_next [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]    full_reg;
    logic [NUM_QUEUES-1:0]    full_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_item_t                out_item_reg;
    out_item_t                out_item_next;

    logic [NUM_QUEUES-1:0]    pending;
    logic                     cfg_we;
    logic [LEN_FIELD_W-1:0]   len_raw;
    logic [QLEN_W-1:0]        len_clamped;
    logic [NUM_QUEUES-1:0]    rising;
    logic                     in_range;
    logic [ID_W-1:0]          post_id;
    logic [1:0]               post_status;
    logic                     post_ok;
    logic [IDX_W-1:0]         w_adv;
    logic [ID_W-1:0]          scan_id;
    logic [IDX_W-1:0]         r_adv;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [EVENT_W-1:0]       ram_rdata;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx,
                                                   input logic [QLEN_W-1:0] len);
        logic [QLEN_W-1:0] n;
        n = QLEN_W'(idx) + QLEN_W'(1);
        return (n >= len) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [ID_W-1:0] id,
                                                     input logic [IDX_W-1:0] slot);
        return ADDR_W'(int'(id) * QUEUE_DEPTH + int'(slot));
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign len_raw   = cfg_data[LEN_FIELD_W-1:0];
    assign rising    = cfg_data[NUM_QUEUES-1:0] & ~mask_reg;

    always_comb
    begin
        if (len_raw == '0)
        begin
            len_clamped = QLEN_W'(1);
        end
        else if (int'(len_raw) > QUEUE_DEPTH)
        begin
            len_clamped = QLEN_W'(QUEUE_DEPTH);
        end
        else
        begin
            len_clamped = QLEN_W'(len_raw);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            pending[i] = mask_reg[i] && (full_reg[i] || (rd_reg[i] != wr_reg[i]));
        end
    end

    assign in_range = ({1'b0, item_reg.priority_level} >= 9'(LOWEST_PRIORITY))
                   && ({1'b0, item_reg.priority_level} < 9'(LOWEST_PRIORITY + NUM_QUEUES));
    assign post_id  = ID_W'(item_reg.priority_level - 8'(LOWEST_PRIORITY));

    always_comb
    begin
        if (!in_range)
        begin
            post_status = ST_OUT_OF_RANGE;
        end
        else if (!mask_reg[post_id])
        begin
            post_status = ST_UNREGISTERED;
        end
        else if (full_reg[post_id])
        begin
            post_status = ST_FULL;
        end
        else
        begin
            post_status = ST_ACCEPTED;
        end
    end

    assign post_ok = (post_status == ST_ACCEPTED);
    assign w_adv   = next_slot(wr_reg[post_id], qlen_reg);

    always_comb
    begin
        scan_id = '0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (todo_reg[i])
            begin
                scan_id = ID_W'(i);
            end
        end
    end

    assign r_adv = next_slot(rd_reg[scan_id], qlen_reg);

    assign ram_we    = cmd.post_do && post_ok;
    assign ram_waddr = store_addr(post_id, wr_reg[post_id]);
    assign ram_re    = cmd.scan_do;
    assign ram_raddr = store_addr(scan_id, rd_reg[scan_id]);

    pedq_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({item_reg.event_signal, item_reg.event_parameter}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        rd_next   = rd_reg;
        wr_next   = wr_reg;
        full_next = full_reg;
        qlen_next = qlen_reg;
        mask_next = mask_reg;
        todo_next = todo_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_QUEUE_LENGTH)
            begin
                qlen_next = len_clamped;
                for (int i = 0; i < NUM_QUEUES; i++)
                begin
                    rd_next[i]   = '0;
                    wr_next[i]   = '0;
                    full_next[i] = 1'b0;
                end
            end
            else if (cfg_index == CFG_REGISTERED_MASK)
            begin
                mask_next = cfg_data[NUM_QUEUES-1:0];
                for (int i = 0; i < NUM_QUEUES; i++)
                begin
                    if (rising[i])
                    begin
                        rd_next[i]   = '0;
                        wr_next[i]   = '0;
                        full_next[i] = 1'b0;
                    end
                end
            end
        end
        if (cmd.latch)
        begin
            todo_next = pending;
        end
        if (ram_we)
        begin
            wr_next[post_id] = w_adv;
            if (w_adv == rd_reg[post_id])
            begin
                full_next[post_id] = 1'b1;
            end
        end
        if (cmd.scan_do)
        begin
            rd_next[scan_id]   = r_adv;
            full_next[scan_id] = 1'b0;
            todo_next[scan_id] = 1'b0;
        end
    end

    always_comb
    begin
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !result_ready;
        if (cmd.post_do)
        begin
            out_item_next             = '0;
            out_item_next.result_kind = KIND_POST;
            out_item_next.post_status = post_status;
            out_item_next.last_result = 1'b1;
            out_valid_next            = 1'b1;
        end
        else if (cmd.load_idle)
        begin
            out_item_next             = '0;
            out_item_next.result_kind = KIND_IDLE;
            out_item_next.last_result = 1'b1;
            out_valid_next            = 1'b1;
        end
        else if (cmd.load_disp)
        begin
            out_item_next.result_kind     = KIND_DISPATCH;
            out_item_next.post_status     = ST_ACCEPTED;
            out_item_next.served_priority = 6'(LOWEST_PRIORITY + int'(disp_id_reg));
            out_item_next.out_signal      = ram_rdata[EVENT_W-1:32];
            out_item_next.out_parameter   = ram_rdata[31:0];
            out_item_next.last_result     = (todo_reg == '0);
            out_valid_next                = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg        <= '{default: '0};
            wr_reg        <= '{default: '0};
            full_reg      <= '0;
            qlen_reg      <= QLEN_W'(QLEN_RESET);
            mask_reg      <= '0;
            todo_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            full_reg      <= full_next;
            qlen_reg      <= qlen_next;
            mask_reg      <= mask_next;
            todo_reg      <= todo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        if (cmd.scan_do)
        begin
            disp_id_reg <= scan_id;
        end
        out_item_reg <= out_item_next;
    end

    assign stat.any_pending = |pending;
    assign stat.todo_empty  = (todo_reg == '0);
    assign stat.out_free    = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    a_scan_hits_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_do |-> pending[scan_id])
        else $error("read issued for a queue with nothing pending");

endmodule

// ===== src/priority_event_queue_dispatcher.sv =====
// ============================================================================
// priority_event_queue_dispatcher: per-priority ring event queues
// One ring queue of signal and parameter words for each priority level from
// 20 to 32, with posting of events and ordered service passes.
// ============================================================================
// Usage:
//   item channel   (item_valid/item_ready/item): one post or service request.
//   result channel (result_valid/result_ready/result): post status, one
//     dispatched event per served queue, or an idle report; last_result marks
//     the final result of a request.
//   cfg channel    (cfg_valid/cfg_ready/cfg_index/cfg_data): queue length and
//   registration mask; always ready; write it only while idle (not enforced).
// Timing: one request at a time. A post or an idle pass is latched, then its
//   result is loaded once the result register is free and the block returns
//   to idle. Each dispatch of a pass is one event memory read followed by a
//   load of the result register, which waits while the register is busy.
// Reset clears all queues, sets the queue length to 4 and unregisters every
// queue. A stalled receiver holds the result register; the sequencer waits
// before loading the next result, and a waiting result does not stop the next
// request from being accepted.
// ============================================================================
module priority_event_queue_dispatcher
    import pedq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  in_item_t               item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output out_item_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    pedq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (item.operation),
        .stat       (stat),
        .cmd        (cmd)
    );

    pedq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule
